@@ hdl/elfrp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfrp_pkg
// Shared types and constants for the ELF relocation patcher.
// ----------------------------------------------------------------------------
package elfrp_pkg;

    // Relocation type numbers
    localparam logic [7:0] K_NONE      = 8'd0;
    localparam logic [7:0] K_PC24      = 8'd1;
    localparam logic [7:0] K_ABS32     = 8'd2;
    localparam logic [7:0] K_REL32     = 8'd3;
    localparam logic [7:0] K_THMCALL   = 8'd10;
    localparam logic [7:0] K_GLOBDAT   = 8'd21;
    localparam logic [7:0] K_JMPSLOT   = 8'd22;
    localparam logic [7:0] K_RELATIVE  = 8'd23;
    localparam logic [7:0] K_PLT32     = 8'd27;
    localparam logic [7:0] K_CALL      = 8'd28;
    localparam logic [7:0] K_JUMP24    = 8'd29;
    localparam logic [7:0] K_THMJUMP24 = 8'd30;
    localparam logic [7:0] K_V4BX      = 8'd40;
    localparam logic [7:0] K_TMOVW     = 8'd47;
    localparam logic [7:0] K_TMOVT     = 8'd48;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_KIND  = 2'd1;
    localparam logic [1:0] ST_THUMB = 2'd2;
    localparam logic [1:0] ST_RSVD  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_LOAD_BASE = 1'b0;
    localparam logic CFG_LINK_BASE = 1'b1;

    // Masks
    localparam logic [31:0] V4BX_KEEP   = 32'hf000000f;
    localparam logic [31:0] V4BX_SET    = 32'h01a0f000;
    localparam logic [31:0] MOV_KEEP    = 32'hFBF08F00;
    localparam logic [15:0] THM_HW0_KEEP = 16'hf800;
    localparam logic [15:0] THM_HW1_KEEP = 16'hd000;
    localparam logic [31:0] THM_BIAS    = 32'h00ffffff;
    localparam logic [31:0] THM_SPAN    = 32'h01fffffe;

    // One relocation as held in the input stage
    typedef struct packed {
        logic [7:0]  reloc_kind;
        logic [31:0] target;
        logic [31:0] orig_word;
        logic [31:0] symbol_addr;
        logic        symbol_is_func;
    } reloc_t;

    // One result
    typedef struct packed {
        logic [31:0] patched_word;
        logic [1:0]  status;
    } result_t;

endpackage

@@ hdl/elfrp_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfrp_req_if
// Request channel: one relocation item per handshake.
// ----------------------------------------------------------------------------
interface elfrp_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  reloc_kind;
    logic [31:0] link_offset;
    logic [31:0] orig_word;
    logic [31:0] symbol_addr;
    logic        symbol_is_func;

    modport source (
        output valid,
        output reloc_kind,
        output link_offset,
        output orig_word,
        output symbol_addr,
        output symbol_is_func,
        input  ready
    );

    modport sink (
        input  valid,
        input  reloc_kind,
        input  link_offset,
        input  orig_word,
        input  symbol_addr,
        input  symbol_is_func,
        output ready
    );
endinterface

@@ hdl/elfrp_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfrp_rsp_if
// Response channel: one patched word and status per handshake.
// ----------------------------------------------------------------------------
interface elfrp_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] patched_word;
    logic [1:0]  status;

    modport source (
        output valid,
        output patched_word,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  patched_word,
        input  status,
        output ready
    );
endinterface

@@ hdl/elfrp_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elfrp_core
// Combinational relocation evaluation: decodes the type and builds the
// patched word and status for one item.
// ----------------------------------------------------------------------------
module elfrp_core (
    input  elfrp_pkg::reloc_t  rel,
    output elfrp_pkg::result_t res
);

    // Thumb MOVW/MOVT immediate insertion (halfwords swapped for the encoding)
    function automatic logic [31:0] put_mov_imm(input logic [31:0] w,
                                                input logic [15:0] imm16);
        logic [31:0] t;
        begin
            t = {w[15:0], w[31:16]} & elfrp_pkg::MOV_KEEP;
            t[19:16] = imm16[15:12];
            t[26]    = imm16[11];
            t[14:12] = imm16[10:8];
            t[7:0]   = imm16[7:0];
            put_mov_imm = {t[15:0], t[31:16]};
        end
    endfunction

    logic [31:0] w;
    logic [31:0] s;
    logic [31:0] diff;
    logic [31:0] br_sum;
    logic [15:0] hw0;
    logic [15:0] hw1;
    logic        sg_in;
    logic [31:0] d_in;
    logic [31:0] d;
    logic [31:0] d_biased;
    logic        thm_bad;
    logic        sg_out;
    logic        b1;
    logic        b2;
    logic [31:0] thm_word;
    logic [31:0] word;
    logic [1:0]  st;

    assign w    = rel.orig_word;
    assign s    = rel.symbol_addr;
    assign diff = s - rel.target;

    // 24-bit branch: sign-extended word offset scaled by 4
    assign br_sum = diff + {{6{w[23]}}, w[23:0], 2'b00};

    // Thumb BL/B.W decode
    assign hw0   = w[15:0];
    assign hw1   = w[31:16];
    assign sg_in = hw0[10];
    assign d_in  = {{7{sg_in}}, sg_in, ~(hw1[13] ^ sg_in), ~(hw1[11] ^ sg_in),
                    hw0[9:0], hw1[10:0], 1'b0};
    assign d        = d_in + diff;
    assign d_biased = d + elfrp_pkg::THM_BIAS;
    assign thm_bad  = !d[0] || (d_biased > elfrp_pkg::THM_SPAN);

    // Thumb re-encode
    assign sg_out   = d[24];
    assign b1       = sg_out ^ ~d[23];
    assign b2       = sg_out ^ ~d[22];
    assign thm_word = {(hw1 & elfrp_pkg::THM_HW1_KEEP) | {2'b00, b1, 1'b0, b2, d[11:1]},
                       (hw0 & elfrp_pkg::THM_HW0_KEEP) | {5'b00000, sg_out, d[21:12]}};

    always_comb
    begin
        word = w;
        st   = elfrp_pkg::ST_OK;
        unique case (rel.reloc_kind) inside
            elfrp_pkg::K_NONE:
            begin
                word = w;
            end
            elfrp_pkg::K_ABS32:
            begin
                word = w + s;
            end
            elfrp_pkg::K_REL32:
            begin
                word = w + diff;
            end
            elfrp_pkg::K_PC24, elfrp_pkg::K_PLT32, elfrp_pkg::K_CALL,
            elfrp_pkg::K_JUMP24:
            begin
                word = {w[31:24], br_sum[25:2]};
            end
            elfrp_pkg::K_V4BX:
            begin
                word = (w & elfrp_pkg::V4BX_KEEP) | elfrp_pkg::V4BX_SET;
            end
            elfrp_pkg::K_GLOBDAT, elfrp_pkg::K_JMPSLOT:
            begin
                word = s;
            end
            elfrp_pkg::K_RELATIVE:
            begin
                word = s + w;
            end
            elfrp_pkg::K_THMCALL, elfrp_pkg::K_THMJUMP24:
            begin
                if (thm_bad)
                begin
                    st = elfrp_pkg::ST_THUMB;
                end
                else
                begin
                    word = thm_word;
                end
            end
            elfrp_pkg::K_TMOVW:
            begin
                word = put_mov_imm(w, {s[15:1], s[0] | rel.symbol_is_func});
            end
            elfrp_pkg::K_TMOVT:
            begin
                word = put_mov_imm(w, s[31:16]);
            end
            default:
            begin
                st = elfrp_pkg::ST_KIND;
            end
        endcase
    end

    assign res.patched_word = word;
    assign res.status       = st;

endmodule

@@ hdl/arm_elf_relocation_patcher.sv @@
// Path: an accepted request is registered in the input stage, then in the result
// stage, which drives the response.
// Throughput: one relocation per cycle while rsp.ready is held high, set by the
// single combinational pass between the two stage registers.
// Reset (rst_n low, asynchronous) empties both stages and clears load_base
// and link_base to zero.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_elf_relocation_patcher
// Applies one ELF relocation per item: computes the run-time target address,
// patches the original word for the relocation type and reports a status.
// ----------------------------------------------------------------------------
module arm_elf_relocation_patcher (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // channels
    elfrp_req_if.sink   req,
    elfrp_rsp_if.source rsp
);

    // Configuration registers
    logic [31:0] load_base_reg;
    logic [31:0] link_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_base_reg <= '0;
            link_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == elfrp_pkg::CFG_LOAD_BASE)
            begin
                load_base_reg <= cfg_data;
            end
            if (cfg_index == elfrp_pkg::CFG_LINK_BASE)
            begin
                link_base_reg <= cfg_data;
            end
        end
    end

    // Stage handshake: each stage loads when empty or when it drains this cycle
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    logic s1_ready;
    logic s2_ready;
    logic req_fire;

    assign s2_ready  = !s2_valid_reg || rsp.ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;
    assign req_fire  = req.valid && s1_ready;

    assign s1_valid_next = req_fire ? 1'b1 : (s2_ready ? 1'b0 : s1_valid_reg);
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Input stage: target address is resolved on the way in
    elfrp_pkg::reloc_t rel_reg;
    elfrp_pkg::reloc_t rel_next;

    always_comb
    begin
        rel_next.reloc_kind     = req.reloc_kind;
        rel_next.target         = load_base_reg + req.link_offset - link_base_reg;
        rel_next.orig_word      = req.orig_word;
        rel_next.symbol_addr    = req.symbol_addr;
        rel_next.symbol_is_func = req.symbol_is_func;
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rel_reg <= rel_next;
        end
    end

    // Evaluation between the stages
    elfrp_pkg::result_t res_next;
    elfrp_pkg::result_t res_reg;

    elfrp_core u_core (
        .rel (rel_reg),
        .res (res_next)
    );

    // Result stage
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid        = s2_valid_reg;
    assign rsp.patched_word = res_reg.patched_word;
    assign rsp.status       = res_reg.status;

`ifndef SYNTHESIS
    // status code 3 is never produced
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (res_reg.status != elfrp_pkg::ST_RSVD))
        else $error("reserved status code on response");

    // a stalled result is kept
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !rsp.ready) |=> s2_valid_reg)
        else $error("stalled result dropped");

    // an accepted item always lands in the input stage
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> s1_valid_reg)
        else $error("accepted item not held in input stage");

    // never accept into a full pipe that cannot drain
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("input accepted while pipeline blocked");

    // a full input stage moves forward whenever the result stage frees up
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> s2_valid_reg)
        else $error("item lost between stages");
`endif

endmodule
